// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true outside reset.
`define SWM_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEFF_BITS_DEF  = 16;
   localparam int MAX_LENGTH      = 4096;

   localparam int FLEN_W  = 13;
   localparam int IDX_W   = 12;
   localparam int WTYPE_W = 3;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_QUO_W = 29;

   localparam logic [WTYPE_W-1:0] WIN_BLACKMAN_HARRIS = 3'd0;
   localparam logic [WTYPE_W-1:0] WIN_GAUSS           = 3'd1;
   localparam logic [WTYPE_W-1:0] WIN_HAMMING         = 3'd2;
   localparam logic [WTYPE_W-1:0] WIN_HANN            = 3'd3;
   localparam logic [WTYPE_W-1:0] WIN_TRIANGULAR      = 3'd4;

   localparam logic CSR_WINDOW_TYPE  = 1'b0;
   localparam logic CSR_FRAME_LENGTH = 1'b1;

   localparam logic [31:0] COS_SEED    = 32'd246762;
   localparam logic [31:0] GAUSS_SCALE = 32'd204800;
   localparam logic [31:0] LOG2E_Q16   = 32'd94548;
   localparam logic [31:0] LN2_Q28     = 32'd186065280;
   localparam logic [2:0]  EXP_TERMS   = 3'd7;
   localparam logic [28:0] Q28_ONE     = 29'h1000_0000;

   typedef enum logic [1:0] {
      DIV_Q16,
      DIV_Q18,
      DIV_Q29
   } div_frac_type;

   typedef struct packed {
      logic                 start;
      div_frac_type         frac;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_QUO_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [27:0] dc_level(logic [WTYPE_W-1:0] wt);
      logic [27:0] val;
      case (wt)
         WIN_BLACKMAN_HARRIS: val = 28'd96301220;
         WIN_HAMMING:         val = 28'd144955146;
         WIN_HANN:            val = 28'd134217728;
         default:             val = 28'd0;
      endcase
      return val;
   endfunction

   function automatic logic [27:0] cos_weight(logic [WTYPE_W-1:0] wt, logic [1:0] k);
      logic [27:0] val;
      val = 28'd0;
      case (wt)
         WIN_BLACKMAN_HARRIS: begin
            case (k)
               2'd1:    val = 28'd131074349;
               2'd2:    val = 28'd37924561;
               2'd3:    val = 28'd3135326;
               default: val = 28'd0;
            endcase
         end
         WIN_HAMMING: val = 28'd123480310;
         WIN_HANN:    val = 28'd134217728;
         default:     val = 28'd0;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] horner_coef(logic [1:0] h);
      logic [31:0] val;
      case (h)
         2'd0:    val = 32'd5600497;
         2'd1:    val = 32'd68093890;
         2'd2:    val = 32'd331168970;
         default: val = 32'd268435456;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/swm_div.sv =====
`timescale 1ns / 1ps

module swm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  swm_pkg::div_req_type req,
   output swm_pkg::div_rsp_type rsp
);
   import swm_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] sh_ff;
   logic [4:0]           cnt_ff;
   logic [DIV_QUO_W-1:0] quot_ff;
   logic                 done_ff;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, sh_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !req.start && (cnt_ff == 5'd1);
         if (req.start) begin
            den_ff  <= req.den;
            quot_ff <= '0;
            case (req.frac)
               DIV_Q16: begin
                  rem_ff <= DIV_DEN_W'(req.num >> 16);
                  sh_ff  <= req.num << 32;
                  cnt_ff <= 5'd16;
               end
               DIV_Q18: begin
                  rem_ff <= DIV_DEN_W'(req.num >> 18);
                  sh_ff  <= req.num << 30;
                  cnt_ff <= 5'd18;
               end
               default: begin
                  rem_ff <= DIV_DEN_W'(req.num >> 29);
                  sh_ff  <= req.num << 19;
                  cnt_ff <= 5'd29;
               end
            endcase
         end else if (cnt_ff != 5'd0) begin
            rem_ff  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            sh_ff   <= sh_ff << 1;
            quot_ff <= {quot_ff[DIV_QUO_W-2:0], ge};
            cnt_ff  <= cnt_ff - 5'd1;
         end
      end
   end

   assign rsp.busy = cnt_ff != 5'd0;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ===== rtl/core/selectable_window_multiplier.sv =====
// Channel | Direction | Handshake            | Beat
// req     | in        | req_valid/req_stall  | req_sample
// rsp     | out       | rsp_valid/rsp_stall  | rsp_windowed_sample, rsp_sample_index,
//         |           |                      | rsp_last_of_frame
// csr     | in        | csr_wen              | csr_index, csr_wdata
//
// One beat at a time. The time per beat depends on the window type and is set by the
// shared restoring divider (16 to 29 steps per division) and the single multiplier,
// which every coefficient term passes through.
// Synchronous active-high reset; registers reset to window type 0, length 1024.
// A new beat is taken while a finished result still waits on rsp_stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module selectable_window_multiplier #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = swm_pkg::COEFF_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_BITS-1:0]     req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SAMPLE_BITS-1:0]     rsp_windowed_sample,
   output logic [swm_pkg::IDX_W-1:0]  rsp_sample_index,
   output logic                       rsp_last_of_frame,
   input  logic                       csr_wen,
   input  logic                       csr_index,
   input  logic [swm_pkg::FLEN_W-1:0] csr_wdata
);
   import swm_pkg::*;

   localparam int CF     = COEFF_BITS - 1;
   localparam int RSH    = 28 - CF;
   localparam int MUL_W  = 34;
   localparam int PROD_W = 64;
   localparam int ACC_W  = 60;
   localparam logic signed [PROD_W-1:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [PROD_W-1:0] SMIN = -SMAX - 64'sd1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_COS_INIT,
      S_COS_MOD,
      S_COS_DIV,
      S_COS_SQ,
      S_COS_V,
      S_COS_HM,
      S_COS_HA,
      S_COS_CL,
      S_COS_ACC,
      S_WIN_RND,
      S_G_DD,
      S_G_DN,
      S_G_MM,
      S_G_DV,
      S_G_XW,
      S_G_Y,
      S_G_F,
      S_G_G,
      S_G_HM,
      S_G_HD,
      S_G_HW,
      S_G_END,
      S_TRI_GO,
      S_TRI_W,
      S_COEF,
      S_RND,
      S_OUT
   } state_type;

   state_type                      state_ff;
   logic [WTYPE_W-1:0]             wtype_ff;
   logic [FLEN_W-1:0]              flen_ff;
   logic [IDX_W-1:0]               pos_ff;
   logic [FLEN_W-1:0]              n_ff;
   logic [IDX_W-1:0]               i_ff;
   logic                           last_ff;
   logic signed [SAMPLE_BITS-1:0]  s_ff;
   logic [1:0]                     k_ff;
   logic [1:0]                     h_ff;
   logic [2:0]                     kk_ff;
   logic [2:0]                     e_ff;
   logic [13:0]                    rem_ff;
   logic [16:0]                    uu_ff;
   logic [16:0]                    v_ff;
   logic                           cneg_ff;
   logic signed [31:0]             t_ff;
   logic [27:0]                    g_ff;
   logic [DIV_NUM_W-1:0]           num_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic [28:0]                    w_ff;
   logic [SAMPLE_BITS-1:0]         res_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic                           rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]         rsp_ws_ff;
   logic [IDX_W-1:0]               rsp_idx_ff;
   logic                           rsp_last_ff;

   logic [FLEN_W-1:0]              n_c;
   logic [IDX_W-1:0]               i_c;
   logic                           last_c;
   logic [IDX_W-1:0]               m_w;
   logic signed [13:0]             sd_w;
   logic [IDX_W-1:0]               d_w;
   logic [FLEN_W-1:0]              cos_den;
   logic [FLEN_W-1:0]              tri_num;
   logic [28:0]                    tmag;
   logic                           term_neg;
   logic [1:0]                     kmax;
   logic [56:0]                    wclamp;
   logic [57:0]                    wround;
   logic [29:0]                    c_full;
   logic [COEFF_BITS-1:0]          coef_c;
   logic signed [PROD_W-1:0]       p_rnd;
   logic signed [PROD_W-1:0]       r_sh;
   logic signed [PROD_W-1:0]       r_sat;
   logic [15:0]                    p_phase;
   logic [15:0]                    u_w;
   logic signed [MUL_W-1:0]        mul_a;
   logic signed [MUL_W-1:0]        mul_b;
   logic signed [2*MUL_W-1:0]      mul_full;
   div_req_type                    div_req;
   div_rsp_type                    div_rsp;

   swm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign n_c = (flen_ff < 13'd2) ? 13'd2 :
                (flen_ff > 13'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : flen_ff;
   assign i_c    = ({1'b0, pos_ff} >= n_c) ? '0 : pos_ff;
   assign last_c = {1'b0, i_c} == (n_c - 13'd1);

   assign m_w     = IDX_W'(n_ff - 13'd1);
   assign sd_w    = $signed({1'b0, i_ff, 1'b0}) - $signed({2'b00, m_w});
   assign d_w     = (sd_w < 14'sd0) ? IDX_W'(-sd_w) : IDX_W'(sd_w);
   assign cos_den = (wtype_ff == WIN_HAMMING) ? n_ff : {1'b0, m_w};
   assign tri_num = n_ff - {1'b0, d_w};
   assign kmax    = (wtype_ff == WIN_BLACKMAN_HARRIS) ? 2'd3 : 2'd1;

   assign tmag = (t_ff < 32'sd0) ? 29'd0 :
                 (t_ff > 32'sd268435456) ? Q28_ONE : t_ff[28:0];
   assign term_neg = k_ff[0] ^ cneg_ff;

   assign wclamp = (acc_ff < 0) ? 57'd0 :
                   (acc_ff > (60'sd1 <<< 56)) ? (57'd1 << 56) : acc_ff[56:0];
   assign wround = {1'b0, wclamp} + (58'd1 << 27);

   assign c_full = ({1'b0, w_ff} + (30'd1 << (27 - CF))) >> RSH;
   assign coef_c = (c_full > (30'd1 << CF)) ? COEFF_BITS'(30'd1 << CF) : COEFF_BITS'(c_full);

   assign p_rnd = prod_ff + (64'sd1 <<< (CF - 1));
   assign r_sh  = p_rnd >>> CF;
   assign r_sat = (r_sh > SMAX) ? SMAX : (r_sh < SMIN) ? SMIN : r_sh;

   assign p_phase = div_rsp.quot[15:0];
   assign u_w     = {p_phase[13:0], 2'b00};

   assign mul_full = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_COS_SQ: begin
            mul_a = MUL_W'(uu_ff);
            mul_b = MUL_W'(uu_ff);
         end
         S_COS_HM: begin
            mul_a = MUL_W'(v_ff);
            mul_b = MUL_W'(t_ff);
         end
         S_COS_CL: begin
            mul_a = MUL_W'(cos_weight(wtype_ff, k_ff));
            mul_b = MUL_W'(tmag);
         end
         S_G_DD: begin
            mul_a = MUL_W'(d_w);
            mul_b = MUL_W'(d_w);
         end
         S_G_DN: begin
            mul_a = MUL_W'(prod_ff[23:0]);
            mul_b = MUL_W'(GAUSS_SCALE);
         end
         S_G_MM: begin
            mul_a = MUL_W'(m_w);
            mul_b = MUL_W'(m_w);
         end
         S_G_Y: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(LOG2E_Q16);
         end
         S_G_F: begin
            mul_a = MUL_W'(prod_ff[31:16]);
            mul_b = MUL_W'(LN2_Q28);
         end
         S_G_HM: begin
            mul_a = MUL_W'(g_ff);
            mul_b = MUL_W'(t_ff);
         end
         S_COEF: begin
            mul_a = MUL_W'(s_ff);
            mul_b = MUL_W'(coef_c);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_req.start = 1'b0;
      div_req.frac  = DIV_Q16;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         S_COS_MOD: begin
            div_req.start = rem_ff < {1'b0, cos_den};
            div_req.num   = DIV_NUM_W'({rem_ff, 16'h0000});
            div_req.den   = DIV_DEN_W'(cos_den);
         end
         S_G_DV: begin
            div_req.start = 1'b1;
            div_req.frac  = DIV_Q18;
            div_req.num   = num_ff;
            div_req.den   = prod_ff[23:0];
         end
         S_G_HD: begin
            div_req.start = 1'b1;
            div_req.frac  = DIV_Q29;
            div_req.num   = DIV_NUM_W'(prod_ff[55:28]);
            div_req.den   = DIV_DEN_W'(kk_ff);
         end
         S_TRI_GO: begin
            div_req.start = 1'b1;
            div_req.frac  = DIV_Q29;
            div_req.num   = DIV_NUM_W'({tri_num, 28'h0000000});
            div_req.den   = DIV_DEN_W'(n_ff);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wtype_ff     <= WIN_BLACKMAN_HARRIS;
         flen_ff      <= 13'd1024;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_WINDOW_TYPE:  wtype_ff <= csr_wdata[WTYPE_W-1:0];
               CSR_FRAME_LENGTH: flen_ff  <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  n_ff    <= n_c;
                  i_ff    <= i_c;
                  last_ff <= last_c;
                  s_ff    <= req_sample;
                  pos_ff  <= last_c ? '0 : i_c + 12'd1;
                  k_ff    <= 2'd1;
                  acc_ff  <= ACC_W'({dc_level(wtype_ff), 28'h0000000});
                  case (wtype_ff)
                     WIN_BLACKMAN_HARRIS, WIN_HAMMING, WIN_HANN: state_ff <= S_COS_INIT;
                     WIN_GAUSS: state_ff <= S_G_DD;
                     default:   state_ff <= S_TRI_GO;
                  endcase
               end
            end
            S_COS_INIT: begin
               case (k_ff)
                  2'd2:    rem_ff <= {1'b0, i_ff, 1'b0};
                  2'd3:    rem_ff <= {2'b00, i_ff} + {1'b0, i_ff, 1'b0};
                  default: rem_ff <= {2'b00, i_ff};
               endcase
               state_ff <= S_COS_MOD;
            end
            S_COS_MOD: begin
               if (rem_ff >= {1'b0, cos_den}) begin
                  rem_ff <= rem_ff - {1'b0, cos_den};
               end else begin
                  state_ff <= S_COS_DIV;
               end
            end
            S_COS_DIV: begin
               if (div_rsp.done) begin
                  uu_ff    <= p_phase[14] ? (17'h10000 - {1'b0, u_w}) : {1'b0, u_w};
                  cneg_ff  <= p_phase[15] ^ p_phase[14];
                  state_ff <= S_COS_SQ;
               end
            end
            S_COS_SQ: begin
               state_ff <= S_COS_V;
            end
            S_COS_V: begin
               v_ff     <= prod_ff[32:16];
               t_ff     <= $signed(COS_SEED);
               h_ff     <= 2'd0;
               state_ff <= S_COS_HM;
            end
            S_COS_HM: begin
               state_ff <= S_COS_HA;
            end
            S_COS_HA: begin
               t_ff <= $signed(horner_coef(h_ff)) - $signed(prod_ff[47:16]);
               if (h_ff == 2'd3) begin
                  state_ff <= S_COS_CL;
               end else begin
                  h_ff     <= h_ff + 2'd1;
                  state_ff <= S_COS_HM;
               end
            end
            S_COS_CL: begin
               state_ff <= S_COS_ACC;
            end
            S_COS_ACC: begin
               acc_ff <= term_neg ? acc_ff - $signed(prod_ff[ACC_W-1:0])
                                  : acc_ff + $signed(prod_ff[ACC_W-1:0]);
               if (k_ff == kmax) begin
                  state_ff <= S_WIN_RND;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_COS_INIT;
               end
            end
            S_WIN_RND: begin
               w_ff     <= wround[56:28];
               state_ff <= S_COEF;
            end
            S_G_DD: begin
               state_ff <= S_G_DN;
            end
            S_G_DN: begin
               state_ff <= S_G_MM;
            end
            S_G_MM: begin
               num_ff   <= prod_ff[DIV_NUM_W-1:0];
               state_ff <= S_G_DV;
            end
            S_G_DV: begin
               state_ff <= S_G_XW;
            end
            S_G_XW: begin
               if (div_rsp.done) begin
                  t_ff     <= $signed(32'(div_rsp.quot));
                  state_ff <= S_G_Y;
               end
            end
            S_G_Y: begin
               state_ff <= S_G_F;
            end
            S_G_F: begin
               e_ff     <= prod_ff[34:32];
               state_ff <= S_G_G;
            end
            S_G_G: begin
               g_ff     <= prod_ff[43:16];
               t_ff     <= $signed(32'(Q28_ONE));
               kk_ff    <= EXP_TERMS;
               state_ff <= S_G_HM;
            end
            S_G_HM: begin
               state_ff <= S_G_HD;
            end
            S_G_HD: begin
               state_ff <= S_G_HW;
            end
            S_G_HW: begin
               if (div_rsp.done) begin
                  t_ff <= $signed(32'(Q28_ONE)) - $signed(32'(div_rsp.quot));
                  if (kk_ff == 3'd1) begin
                     state_ff <= S_G_END;
                  end else begin
                     kk_ff    <= kk_ff - 3'd1;
                     state_ff <= S_G_HM;
                  end
               end
            end
            S_G_END: begin
               w_ff     <= 29'(t_ff >> e_ff);
               state_ff <= S_COEF;
            end
            S_TRI_GO: begin
               state_ff <= S_TRI_W;
            end
            S_TRI_W: begin
               if (div_rsp.done) begin
                  w_ff     <= div_rsp.quot;
                  state_ff <= S_COEF;
               end
            end
            S_COEF: begin
               state_ff <= S_RND;
            end
            S_RND: begin
               res_ff   <= r_sat[SAMPLE_BITS-1:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ws_ff    <= res_ff;
                  rsp_idx_ff   <= i_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_windowed_sample = rsp_ws_ff;
   assign rsp_sample_index    = rsp_idx_ff;
   assign rsp_last_of_frame   = rsp_last_ff;

   `SWM_NEVER(a_div_overlap, div_req.start && div_rsp.busy, "divider restarted while busy")
   `SWM_ASSERT(a_rsp_src, $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT), "rsp off S_OUT")
   `SWM_ASSERT(a_pos_wrap, (req_valid && !req_stall) |=> ((pos_ff == '0) == $past(last_c)), "wrap")
   `SWM_NEVER(a_term_range, (state_ff == S_COS_ACC) && (k_ff > kmax), "cosine term beyond order")

endmodule
